FILE: hw/rtl/ihsd_pkg.sv
// ihsd_pkg: shared types and constants for integer_hash_set_dedup
// no dependencies
package ihsd_pkg;

  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 8;
  localparam int KEY_W       = 64;
  localparam int CNT_W       = 14;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BCOUNT = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [31:0] MULT_RST   = 32'd31;
  localparam logic [30:0] OFFSET_RST = 31'd13;
  localparam logic [30:0] MOD_RST    = 31'd17;
  localparam logic [10:0] BCOUNT_RST = 11'd16;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } ihsd_in_t;

  typedef struct packed {
    logic             present;
    logic             added;
    logic             bucket_full;
    logic [CNT_W-1:0] distinct_count;
  } ihsd_out_t;

endpackage

FILE: hw/rtl/ihsd_ram.sv
// ihsd_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module ihsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/integer_hash_set_dedup.sv
// integer_hash_set_dedup: hash set with insert and membership query
// depends on ihsd_pkg and ihsd_ram
//
// usage: one transaction on in_* carries an op (insert or query) and a 64-bit
// signed key; each one yields exactly one transaction on out_* with present,
// added, bucket_full and the distinct key count. cfg_* writes the hash
// multiplier, offset, modulus and bucket count; write only while idle.
// steps: shift-add multiply, magnitude, bit-serial remainder in one
// compare/subtract unit, the bucket fill read, a read and a compare per
// compared slot, and the update.
// one transaction at a time: in_ready is high only while idle.
// the result sits in an output register; a stalled receiver holds it there
// and the next transaction is taken meanwhile, stalling only when its own
// result is ready before the previous one has been taken.
// reset: state, config, count and output-valid registers return to defaults,
// then a clearing pass zeroes every bucket fill entry; in_ready stays low during it.
module integer_hash_set_dedup
  import ihsd_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ihsd_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ihsd_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int BW = $clog2(BUCKETS);
  localparam int AW = $clog2(BUCKETS * WAYS);
  localparam int FW = $clog2(WAYS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MUL, S_ABS, S_DIV, S_FILL, S_FWAIT, S_RD, S_CMP, S_UPD
  } state_t;

  state_t           state_r, state_nxt;
  logic [31:0]      mult_r, mult_nxt;
  logic [30:0]      offset_r, offset_nxt;
  logic [30:0]      mod_r, mod_nxt;
  logic [10:0]      bcount_r, bcount_nxt;
  logic             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] acc_r, acc_nxt;
  logic [KEY_W-1:0] ksh_r, ksh_nxt;
  logic [KEY_W-1:0] dvd_r, dvd_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [30:0]      rem_r, rem_nxt;
  logic [30:0]      div_r, div_nxt;
  logic             pass2_r, pass2_nxt;
  logic [BW-1:0]    bkt_r, bkt_nxt;
  logic [BW-1:0]    clr_r, clr_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [FW-1:0]    way_r, way_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  ihsd_out_t        out_data_r, out_data_nxt;

  logic [KEY_W-1:0] add_a, add_b, add_sum;
  logic             add_sub;
  logic [31:0]      div_t, div_diff;
  logic             div_ge;
  logic [30:0]      pm, nb;

  logic             slot_we, fill_we;
  logic [AW-1:0]    slot_waddr, slot_raddr;
  logic [KEY_W-1:0] slot_rdata;
  logic [BW-1:0]    fill_waddr;
  logic [FW-1:0]    fill_wdata, fill_rdata;

  ihsd_ram #(.WIDTH(KEY_W), .DEPTH(BUCKETS * WAYS)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (key_r),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ihsd_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (bkt_r),
    .rdata (fill_rdata)
  );

  assign slot_raddr = AW'(bkt_r) * AW'(WAYS) + AW'(way_r);
  assign slot_waddr = AW'(bkt_r) * AW'(WAYS) + AW'(fill_r);

  assign pm = (mod_r == 31'd0) ? 31'd1 : mod_r;
  assign nb = (bcount_r == 11'd0) ? 31'd1 :
              ({20'd0, bcount_r} > 31'(BUCKETS)) ? 31'(BUCKETS) : {20'd0, bcount_r};

  // shared 64-bit add/subtract
  always_comb begin
    add_a   = acc_r;
    add_b   = ksh_r;
    add_sub = (cnt_r == 6'd31);
    if (state_r == S_ABS) begin
      add_a   = '0;
      add_b   = acc_r;
      add_sub = acc_r[KEY_W-1];
    end
    add_sum = add_a + (add_sub ? ~add_b : add_b) + KEY_W'(add_sub);
  end

  // shared compare/subtract for the remainder
  assign div_t    = {rem_r, dvd_r[KEY_W-1]};
  assign div_ge   = (div_t >= {1'b0, div_r});
  assign div_diff = div_t - {1'b0, div_r};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    mult_nxt      = mult_r;
    offset_nxt    = offset_r;
    mod_nxt       = mod_r;
    bcount_nxt    = bcount_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    acc_nxt       = acc_r;
    ksh_nxt       = ksh_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    pass2_nxt     = pass2_r;
    bkt_nxt       = bkt_r;
    clr_nxt       = clr_r;
    fill_nxt      = fill_r;
    way_nxt       = way_r;
    found_nxt     = found_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    slot_we       = 1'b0;
    fill_we       = 1'b0;
    fill_waddr    = bkt_r;
    fill_wdata    = fill_r + FW'(1);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_MULT:   mult_nxt   = cfg_data;
        CFG_OFFSET: offset_nxt = cfg_data[30:0];
        CFG_MOD:    mod_nxt    = cfg_data[30:0];
        CFG_BCOUNT: bcount_nxt = cfg_data[10:0];
        default:    ;
      endcase
    end

    case (state_r)
      S_CLR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r;
        fill_wdata = '0;
        clr_nxt    = clr_r + BW'(1);
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          key_nxt   = in_data.key;
          ksh_nxt   = in_data.key;
          acc_nxt   = {33'd0, offset_r};
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mult_r[cnt_r[4:0]]) begin
          acc_nxt = add_sum;
        end
        ksh_nxt = {ksh_r[KEY_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        dvd_nxt   = add_sum;
        rem_nxt   = '0;
        div_nxt   = pm;
        pass2_nxt = 1'b0;
        cnt_nxt   = 6'd63;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = div_ge ? div_diff[30:0] : div_t[30:0];
        dvd_nxt = {dvd_r[KEY_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          if (!pass2_r) begin
            pass2_nxt = 1'b1;
            dvd_nxt   = {rem_nxt, 33'd0};
            rem_nxt   = '0;
            div_nxt   = nb;
            cnt_nxt   = 6'd30;
          end else begin
            bkt_nxt   = rem_nxt[BW-1:0];
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        fill_nxt  = fill_rdata;
        way_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = (fill_rdata == '0) ? S_UPD : S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (slot_rdata == key_r) begin
          found_nxt = 1'b1;
          state_nxt = S_UPD;
        end else if (way_r + FW'(1) == fill_r) begin
          state_nxt = S_UPD;
        end else begin
          way_nxt   = way_r + FW'(1);
          state_nxt = S_RD;
        end
      end
      S_UPD: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.present     = found_r;
          out_data_nxt.added       = 1'b0;
          out_data_nxt.bucket_full = 1'b0;
          if (op_r == OP_INSERT && !found_r) begin
            if (fill_r < FW'(WAYS)) begin
              slot_we                = 1'b1;
              fill_we                = 1'b1;
              total_nxt              = total_r + CNT_W'(1);
              out_data_nxt.added     = 1'b1;
            end else begin
              out_data_nxt.bucket_full = 1'b1;
            end
          end
          out_data_nxt.distinct_count = total_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      mult_r      <= MULT_RST;
      offset_r    <= OFFSET_RST;
      mod_r       <= MOD_RST;
      bcount_r    <= BCOUNT_RST;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mult_r      <= mult_nxt;
      offset_r    <= offset_nxt;
      mod_r       <= mod_nxt;
      bcount_r    <= bcount_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    acc_r      <= acc_nxt;
    ksh_r      <= ksh_nxt;
    dvd_r      <= dvd_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    pass2_r    <= pass2_nxt;
    bkt_r      <= bkt_nxt;
    fill_r     <= fill_nxt;
    way_r      <= way_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
